// ----- hdl/mmf_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants of the moving median filter
// no dependencies; used by the interfaces, the cells, the controller and the top level
package mmf_pkg;

	localparam int SAMPLE_W       = 32;
	localparam int WLEN_W         = 6;
	localparam int WINDOW_MAX_DEF = 32;
	localparam logic [WLEN_W-1:0] WLEN_RESET = 6'd5;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COUNT,
		ST_PICK
	} state_t;

	// controls broadcast from the sequencer to the row of cells and the output stage
	typedef struct packed {
		logic load;
		logic cmp;
		logic pick;
	} ctrl_t;

endpackage

// ----- hdl/mmf_in_if.sv -----
`timescale 1ns / 1ps
// input channel: one sample word with its clear flag, valid/ready handshake
// depends on mmf_pkg
interface mmf_in_if;
	logic              valid;
	logic              ready;
	mmf_pkg::sample_t  sample;
	logic              clear_history;

	modport source (output valid, output sample, output clear_history, input ready);
	modport sink (input valid, input sample, input clear_history, output ready);
endinterface

// ----- hdl/mmf_out_if.sv -----
`timescale 1ns / 1ps
// output channel: one median word, valid/ready handshake
// depends on mmf_pkg
interface mmf_out_if;
	logic              valid;
	logic              ready;
	mmf_pkg::sample_t  median_value;

	modport source (output valid, output median_value, input ready);
	modport sink (input valid, input median_value, output ready);
endinterface

// ----- hdl/mmf_cell.sv -----
`timescale 1ns / 1ps
// one window cell: history tap, shifting copy and rank counters
// depends on mmf_pkg
module mmf_cell #(
	parameter int CNT_W = 6
) (
	input  logic                 clk,
	input  mmf_pkg::ctrl_t       ctrl,
	input  mmf_pkg::sample_t     hist_in,
	input  mmf_pkg::sample_t     ring_in,
	input  mmf_pkg::sample_t     bcast,
	input  logic [CNT_W-1:0]     k,
	input  logic                 active,
	output mmf_pkg::sample_t     hist_out,
	output mmf_pkg::sample_t     ring_out,
	output mmf_pkg::sample_t     pick_val,
	output logic                 hit
);

	mmf_pkg::sample_t  hist_q;
	mmf_pkg::sample_t  ring_q;
	logic [CNT_W-1:0]  less_q;
	logic [CNT_W-1:0]  le_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			hist_q <= hist_in;
			ring_q <= hist_in;
			less_q <= '0;
			le_q   <= '0;
		end else if (ctrl.cmp) begin
			ring_q <= ring_in;
			if (bcast < hist_q) begin
				less_q <= less_q + CNT_W'(1);
			end
			if (bcast <= hist_q) begin
				le_q <= le_q + CNT_W'(1);
			end
		end
	end

	// this cell holds the k-th smallest when its rank interval covers k
	assign hit      = active && (less_q <= k) && (k < le_q);
	assign pick_val = hit ? hist_q : '0;
	assign hist_out = hist_q;
	assign ring_out = ring_q;

endmodule

// ----- hdl/mmf_ctrl.sv -----
`timescale 1ns / 1ps
// sequencer: idle, count passes over the window, pick into the output register
// depends on mmf_pkg
module mmf_ctrl #(
	parameter int CNT_W = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              w_zero,
	input  logic [CNT_W-1:0]  n_new,
	input  logic              out_free,
	output logic              in_ready,
	output mmf_pkg::ctrl_t    ctrl
);

	mmf_pkg::state_t   st_q;
	mmf_pkg::state_t   st_nxt;
	logic [CNT_W-1:0]  cnt_q;

	always_comb begin
		st_nxt = st_q;
		unique case (st_q)
			mmf_pkg::ST_IDLE: begin
				if (in_valid) begin
					st_nxt = w_zero ? mmf_pkg::ST_PICK : mmf_pkg::ST_COUNT;
				end
			end
			mmf_pkg::ST_COUNT: begin
				if (cnt_q == CNT_W'(1)) begin
					st_nxt = mmf_pkg::ST_PICK;
				end
			end
			mmf_pkg::ST_PICK: begin
				if (out_free) begin
					st_nxt = mmf_pkg::ST_IDLE;
				end
			end
			default: st_nxt = mmf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (st_q == mmf_pkg::ST_IDLE);
		ctrl.load = (st_q == mmf_pkg::ST_IDLE) && in_valid && !w_zero;
		ctrl.cmp  = (st_q == mmf_pkg::ST_COUNT);
		ctrl.pick = (st_q == mmf_pkg::ST_PICK) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= mmf_pkg::ST_IDLE;
			cnt_q <= '0;
		end else begin
			st_q <= st_nxt;
			if (ctrl.load) begin
				cnt_q <= n_new;
			end else if (ctrl.cmp) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == mmf_pkg::ST_COUNT |-> cnt_q != '0)
		else $error("compare pass counter hit zero while counting");

endmodule

// ----- hdl/moving_median_filter_top.sv -----
`timescale 1ns / 1ps
// top level of the moving median filter: config register, cell row, sequencer, output register
// depends on mmf_pkg, mmf_in_if, mmf_out_if, mmf_cell, mmf_ctrl
//
// usage
//   samples : sink channel, one word = signed Q16.16 sample plus clear_history flag
//   medians : source channel, one word = upper median of the kept samples
//   cfg_we / cfg_wdata : window_length register, write only while the block is idle
// operation
//   an accepted word shifts into a row of WINDOW_MAX cells (newest at cell 0) and a
//   copy of the row starts to circulate toward cell 0; the copy at cell 0 is broadcast
//   once for each kept sample and every cell counts how many kept samples are below /
//   not above its own value; the cell whose rank range covers n/2 supplies the median
// flow
//   an accepted word is compared over n broadcasts, n = kept samples (1..WINDOW_MAX),
//   then picked into the output register; pass-through (window_length 0) skips the
//   count state; one word in flight at a time, as samples.ready is high only in idle
//   and the next word waits until the previous one has been picked
//   a new word is taken while the previous result still waits in the output register
// reset
//   arst_n clears the sequencer, the fill count and the output valid; window_length
//   returns to 5; cell contents stay undefined and are never read before written
// stall
//   when medians.ready is low the finished result holds and the next result waits in
//   the pick state, so samples.ready stays low until the output register frees up
module moving_median_filter_top #(
	parameter int WINDOW_MAX = mmf_pkg::WINDOW_MAX_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	mmf_in_if.sink                      samples,
	mmf_out_if.source                   medians,
	input  logic                        cfg_we,
	input  logic [mmf_pkg::WLEN_W-1:0]  cfg_wdata
);

	localparam int CNT_W = $clog2(WINDOW_MAX + 1);

	// config register
	logic [mmf_pkg::WLEN_W-1:0] window_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= mmf_pkg::WLEN_RESET;
		end else if (cfg_we) begin
			window_length_q <= cfg_wdata;
		end
	end

	// effective window, clamped to the cell count
	logic [CNT_W-1:0] w_eff;
	logic             w_zero;

	always_comb begin
		if (32'(window_length_q) > 32'(WINDOW_MAX)) begin
			w_eff = CNT_W'(WINDOW_MAX);
		end else begin
			w_eff = CNT_W'(window_length_q);
		end
	end
	assign w_zero = (window_length_q == '0);

	// fill count after this word
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] fill_base;
	logic [CNT_W:0]   fill_inc;
	logic [CNT_W-1:0] n_new;

	assign fill_base = samples.clear_history ? '0 : fill_q;
	assign fill_inc  = {1'b0, fill_base} + (CNT_W + 1)'(1);
	assign n_new     = (fill_inc > {1'b0, w_eff}) ? w_eff : fill_inc[CNT_W-1:0];

	// sequencer
	mmf_pkg::ctrl_t ctrl;
	logic           in_ready;
	logic           out_free;
	logic           accept;

	logic           out_v_q;
	mmf_pkg::sample_t median_q;

	assign out_free = !out_v_q || medians.ready;
	assign accept   = samples.valid && in_ready;

	mmf_ctrl #(
		.CNT_W (CNT_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.w_zero   (w_zero),
		.n_new    (n_new),
		.out_free (out_free),
		.in_ready (in_ready),
		.ctrl     (ctrl)
	);

	assign samples.ready = in_ready;

	// fill count and pass-through word
	logic             pass_q;
	mmf_pkg::sample_t sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			pass_q <= 1'b0;
		end else if (accept) begin
			fill_q <= w_zero ? '0 : n_new;
			pass_q <= w_zero;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= samples.sample;
		end
	end

	// row of cells
	mmf_pkg::sample_t hist_w [WINDOW_MAX];
	mmf_pkg::sample_t ring_w [WINDOW_MAX];
	mmf_pkg::sample_t pick_w [WINDOW_MAX];
	logic [WINDOW_MAX-1:0] hit_w;
	logic [CNT_W-1:0] k;

	// median rank: floor(n/2), the upper median for even n
	assign k = fill_q >> 1;

	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		mmf_pkg::sample_t hist_prev;
		mmf_pkg::sample_t ring_next;

		if (i == 0) begin : g_head
			assign hist_prev = samples.sample;
		end else begin : g_body
			assign hist_prev = hist_w[i-1];
		end

		if (i == WINDOW_MAX - 1) begin : g_tail
			assign ring_next = '0;
		end else begin : g_link
			assign ring_next = ring_w[i+1];
		end

		mmf_cell #(
			.CNT_W (CNT_W)
		) u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.hist_in  (hist_prev),
			.ring_in  (ring_next),
			.bcast    (ring_w[0]),
			.k        (k),
			.active   (fill_q > CNT_W'(i)),
			.hist_out (hist_w[i]),
			.ring_out (ring_w[i]),
			.pick_val (pick_w[i]),
			.hit      (hit_w[i])
		);
	end

	// all hitting cells hold equal values, so an or of the masked values selects the median
	mmf_pkg::sample_t pick_or;

	always_comb begin
		pick_or = '0;
		for (int i = 0; i < WINDOW_MAX; i++) begin
			pick_or = pick_or | pick_w[i];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (ctrl.pick) begin
			out_v_q <= 1'b1;
		end else if (medians.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.pick) begin
			median_q <= pass_q ? sample_q : pick_or;
		end
	end

	assign medians.valid        = out_v_q;
	assign medians.median_value = median_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) <= 32'(WINDOW_MAX))
		else $error("fill count beyond cell count");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !samples.ready)
		else $error("second word taken while one is in flight");

	a_pick_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.pick |=> medians.valid)
		else $error("picked result not presented");

	a_median_found: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.pick && !pass_q) |-> hit_w != '0)
		else $error("no cell matched the median rank");

endmodule
